[hdl/afr_pkg.sv]
// ----------------------------------------------------------------------------
// afr_pkg: shared types and constants of the addressed frame receiver
// Field widths, frame marks, event codes and the result record.
// ----------------------------------------------------------------------------
package afr_pkg;

    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 9;
    localparam int EVENT_W  = 3;
    localparam int HDR_DEPTH = 6;
    localparam int HDR_IDX_W = $clog2(HDR_DEPTH);
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [BYTE_W-1:0] START_MARK  = 8'h7E;
    localparam logic [BYTE_W-1:0] ADDR_NONE   = 8'h00;
    localparam logic [BYTE_W-1:0] TYPE_SKIP_A = 8'h0C;
    localparam logic [BYTE_W-1:0] TYPE_SKIP_B = 8'h0D;

    // Frame positions that matter to the decode
    localparam logic [COUNT_W-1:0] CNT_DECIDE    = 9'd5;
    localparam logic [COUNT_W-1:0] CNT_REPLY_END = 9'd8;
    localparam logic [COUNT_W-1:0] DATA_OVERHEAD = 9'd7;

    // Register word indexes
    localparam logic REG_BOARD_ID = 1'b0;

    typedef enum logic [EVENT_W-1:0] {
        EV_IN_FRAME        = 3'd0,
        EV_DROPPED         = 3'd1,
        EV_REPLY_COUNTED   = 3'd2,
        EV_REPLY_UNCOUNTED = 3'd3,
        EV_DATA_DONE       = 3'd4,
        EV_CLEARED         = 3'd5
    } event_t;

    typedef struct packed {
        logic [EVENT_W-1:0] frame_event;
        logic [COUNT_W-1:0] byte_position;
        logic [BYTE_W-1:0]  out_byte;
        logic [BYTE_W-1:0]  frame_length;
        logic [BYTE_W-1:0]  reply_total;
        logic               send_failed;
        logic               data_ready;
    } result_t;

endpackage

[hdl/afr_in_if.sv]
// ----------------------------------------------------------------------------
// afr_in_if: input channel of the addressed frame receiver
// Valid/ready channel carrying one command and one received byte.
// ----------------------------------------------------------------------------
interface afr_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [afr_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

[hdl/afr_out_if.sv]
// ----------------------------------------------------------------------------
// afr_out_if: result channel of the addressed frame receiver
// Valid/ready channel carrying one framing result per transfer.
// ----------------------------------------------------------------------------
interface afr_out_if;
    logic                         valid;
    logic                         ready;
    logic [afr_pkg::EVENT_W-1:0]  frame_event;
    logic [afr_pkg::COUNT_W-1:0]  byte_position;
    logic [afr_pkg::BYTE_W-1:0]   out_byte;
    logic [afr_pkg::BYTE_W-1:0]   frame_length;
    logic [afr_pkg::BYTE_W-1:0]   reply_total;
    logic                         send_failed;
    logic                         data_ready;

    modport source (output valid, output frame_event, output byte_position,
                    output out_byte, output frame_length, output reply_total,
                    output send_failed, output data_ready, input ready);
    modport sink   (input valid, input frame_event, input byte_position,
                    input out_byte, input frame_length, input reply_total,
                    input send_failed, input data_ready, output ready);
endinterface

[hdl/afr_frame_core.sv]
// ----------------------------------------------------------------------------
// afr_frame_core: framing state and per-byte decode
// Holds header bytes, byte count, length, reply counter and sticky flags,
// and computes the result for the byte presented on step.
// ----------------------------------------------------------------------------
module afr_frame_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        command,
    input  logic [afr_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [afr_pkg::BYTE_W-1:0]  board_id,
    output afr_pkg::result_t            result
);

    logic [afr_pkg::BYTE_W-1:0]  hdr_reg [afr_pkg::HDR_DEPTH];
    logic [afr_pkg::BYTE_W-1:0]  hdr_eff [afr_pkg::HDR_DEPTH];
    logic [afr_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [afr_pkg::BYTE_W-1:0]  length_reg, length_next;
    logic [afr_pkg::BYTE_W-1:0]  reply_reg, reply_next;
    logic                        fail_reg, fail_next;
    logic                        ready_reg, ready_next;
    logic [afr_pkg::COUNT_W-1:0] cnt;
    logic [afr_pkg::COUNT_W-1:0] data_end;
    logic                        hdr_write;
    afr_pkg::event_t             ev;

    assign cnt       = count_reg + 9'd1;
    assign hdr_write = !command && (count_reg < afr_pkg::COUNT_W'(afr_pkg::HDR_DEPTH));
    assign data_end  = {1'b0, length_next} + afr_pkg::DATA_OVERHEAD;

    // Overlay the current byte on the stored header
    always_comb
    begin
        for (int i = 0; i < afr_pkg::HDR_DEPTH; i++)
        begin
            if (count_reg == afr_pkg::COUNT_W'(i))
                hdr_eff[i] = rx_byte;
            else
                hdr_eff[i] = hdr_reg[i];
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        length_next = length_reg;
        reply_next  = reply_reg;
        fail_next   = fail_reg;
        ready_next  = ready_reg;
        ev          = afr_pkg::EV_IN_FRAME;

        if (command)
        begin
            reply_next = '0;
            fail_next  = 1'b0;
            ready_next = 1'b0;
            ev         = afr_pkg::EV_CLEARED;
        end
        else
        begin
            count_next = cnt;
            if (hdr_eff[0] != afr_pkg::START_MARK)
            begin
                count_next = '0;
                ev         = afr_pkg::EV_DROPPED;
            end
            else if (cnt >= afr_pkg::CNT_DECIDE)
            begin
                if (hdr_eff[1] == board_id && hdr_eff[2] == afr_pkg::ADDR_NONE)
                begin
                    if (cnt == afr_pkg::CNT_REPLY_END)
                    begin
                        count_next = '0;
                        if (hdr_eff[3] != afr_pkg::TYPE_SKIP_A &&
                            hdr_eff[3] != afr_pkg::TYPE_SKIP_B)
                        begin
                            reply_next = reply_reg + 8'd1;
                            if (hdr_eff[5] == 8'd0)
                                fail_next = 1'b1;
                            ev = afr_pkg::EV_REPLY_COUNTED;
                        end
                        else
                        begin
                            ev = afr_pkg::EV_REPLY_UNCOUNTED;
                        end
                    end
                end
                else if (hdr_eff[2] == board_id)
                begin
                    if (cnt == afr_pkg::CNT_DECIDE)
                        length_next = hdr_eff[4];
                    if (cnt == data_end)
                    begin
                        count_next = '0;
                        ready_next = 1'b1;
                        ev         = afr_pkg::EV_DATA_DONE;
                    end
                end
                else
                begin
                    count_next = '0;
                    ev         = afr_pkg::EV_DROPPED;
                end
            end
        end
    end

    always_comb
    begin
        result.frame_event   = ev;
        result.byte_position = command ? '0 : count_reg;
        result.out_byte      = command ? '0 : rx_byte;
        result.frame_length  = length_next;
        result.reply_total   = reply_next;
        result.send_failed   = fail_next;
        result.data_ready    = ready_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            length_reg <= '0;
            reply_reg  <= '0;
            fail_reg   <= 1'b0;
            ready_reg  <= 1'b0;
        end
        else if (step)
        begin
            count_reg  <= count_next;
            length_reg <= length_next;
            reply_reg  <= reply_next;
            fail_reg   <= fail_next;
            ready_reg  <= ready_next;
        end
    end

    // Header bytes: payload only, no reset
    always_ff @(posedge clk)
    begin
        if (step && hdr_write)
            hdr_reg[count_reg[afr_pkg::HDR_IDX_W-1:0]] <= rx_byte;
    end

endmodule

[hdl/addressed_frame_receiver_top.sv]
// ----------------------------------------------------------------------------
// addressed_frame_receiver_top: frames received bytes by board address
// Input register, framing core and result register, with an APB port for
// the board id.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per transfer: command 0 frames rx_byte, command 1
//   clears the ready flag, fail flag and reply counter.
//   out_ch returns exactly one result per input item, in order.
//   The APB port holds board_id at byte addresses 0 to 3; write it only while the
//   block is idle. pready is always high; prdata returns board_id there, else zero.
// Path: an item taken from in_ch is registered at the input, its result is
//   registered in the result register and offered on out_ch from there.
// Throughput: one item per cycle while out_ch does not stall; the combinational
//   decode of the framing core between the input and result registers sets it.
// Reset: clears byte count, length, reply counter, flags and board_id; both
//   pipeline registers become empty.
// Stall: a result held on out_ch keeps the input register full; in_ch.ready
//   is low while both registers hold an item and out_ch.ready is low.
// ----------------------------------------------------------------------------
module addressed_frame_receiver_top (
    input  logic                            clk,
    input  logic                            rst_n,
    afr_in_if.sink                          in_ch,
    afr_out_if.source                       out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [afr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [afr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [afr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    logic                        in_valid_reg;
    logic                        in_cmd_reg;
    logic [afr_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                        out_valid_reg;
    afr_pkg::result_t            out_data_reg;
    afr_pkg::result_t            core_result;
    logic [afr_pkg::BYTE_W-1:0]  board_id_reg;
    logic                        fire;
    logic                        reg_sel;

    assign fire         = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || fire;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_sel = (paddr[afr_pkg::APB_ADDR_W-1:2] == afr_pkg::REG_BOARD_ID);
    assign prdata  = reg_sel ? {{(afr_pkg::APB_DATA_W-afr_pkg::BYTE_W){1'b0}}, board_id_reg}
                             : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            board_id_reg <= '0;
        else if (psel && penable && pwrite && pready && reg_sel)
            board_id_reg <= pwdata[afr_pkg::BYTE_W-1:0];
    end

    // Input register: load on every input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ch.ready)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_cmd_reg  <= in_ch.command;
            in_byte_reg <= in_ch.rx_byte;
        end
    end

    afr_frame_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (fire),
        .command  (in_cmd_reg),
        .rx_byte  (in_byte_reg),
        .board_id (board_id_reg),
        .result   (core_result)
    );

    // Result register: hold while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_data_reg <= core_result;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.frame_event   = out_data_reg.frame_event;
    assign out_ch.byte_position = out_data_reg.byte_position;
    assign out_ch.out_byte      = out_data_reg.out_byte;
    assign out_ch.frame_length  = out_data_reg.frame_length;
    assign out_ch.reply_total   = out_data_reg.reply_total;
    assign out_ch.send_failed   = out_data_reg.send_failed;
    assign out_ch.data_ready    = out_data_reg.data_ready;

endmodule
